[hw/rtl/hds_pkg.sv]
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants of the 1D heat diffusion step
// Temperature format, register indexes, reset values and saturation helper.
// ----------------------------------------------------------------------------
package hds_pkg;

	localparam int NUM_POINTS_DEF = 32;

	localparam int TEMP_W    = 24;
	localparam int GAIN_W    = 16;
	localparam int IDX_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int LAP_W     = TEMP_W + 2;
	localparam int PROD_W    = LAP_W + GAIN_W + 1;
	localparam int SUM_W     = TEMP_W + 4;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [GAIN_W-1:0]        gain_t;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd3;

	localparam temp_t RST_INITIAL = 24'sd12800;
	localparam temp_t RST_LEFT    = 24'sd25600;
	localparam temp_t RST_RIGHT   = 24'sd0;
	localparam gain_t RST_GAIN    = 16'd2621;

	localparam temp_t TEMP_MAX = 24'sh7FFFFF;
	localparam temp_t TEMP_MIN = 24'sh800000;

	// control of one slot entering the pipeline
	typedef struct packed {
		logic valid;
		logic restart;
	} issue_t;

	// clamp a widened sum to the temperature range
	function automatic temp_t sat_temp(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(TEMP_MAX);
		lo = SUM_W'(TEMP_MIN);
		if (v > hi) begin
			return TEMP_MAX;
		end else if (v < lo) begin
			return TEMP_MIN;
		end else begin
			return v[TEMP_W-1:0];
		end
	endfunction

endpackage

[hw/rtl/heat_diffusion_step_1d_top.sv]
// ----------------------------------------------------------------------------
// heat_diffusion_step_1d_top: explicit 1D heat equation step engine
// Holds a rod temperature profile in a memory, reloads it or advances it
// one forward-Euler step per item, and streams every point out.
// ----------------------------------------------------------------------------
//
//   channel   signals                              moves
//   --------  -----------------------------------  ---------------------------
//   in        in_valid/in_ready, restart           one item per transfer
//   out       out_valid/out_ready, point_index,    one point per transfer,
//             temperature, last                    NUM_POINTS per item
//   cfg       cfg_valid/cfg_ready, cfg_index,      one register per transfer
//             cfg_data
//
// Without output stalls the sequencer reads one profile entry per cycle over
// NUM_POINTS + 1 slots, then three pipeline stages drain into the output
// register. The single read port of the profile memory sets that pace.
// in_ready drops on a transfer and rises once the last point is written back.
// A stall on the output freezes the whole pipeline, memory read included.
// Reset loads the registers with their defaults; the memory is not cleared,
// a power-on flag serves the default profile until the first item is done.
//
module heat_diffusion_step_1d_top import hds_pkg::*; #(
	parameter int NUM_POINTS = NUM_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_W-1:0]     point_index,
	output temp_t                temperature,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TEMP_W-1:0]    cfg_data
);

	localparam int AW = $clog2(NUM_POINTS);
	localparam int SW = $clog2(NUM_POINTS + 1);
	localparam logic [SW-1:0] S_END = SW'(NUM_POINTS);

	// configuration registers
	temp_t init_q;
	temp_t left_q;
	temp_t right_q;
	gain_t gain_q;

	// sequencer
	logic          busy_q;
	logic          issuing_q;
	logic          restart_q;
	logic          virgin_q;
	logic [SW-1:0] cnt_q;

	logic          adv;
	issue_t        issue;
	temp_t         rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	temp_t         wr_data;
	logic          done;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;

	// hold every stage while a point waits on the output
	assign adv = !out_valid || out_ready;

	assign issue.valid   = issuing_q;
	assign issue.restart = restart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= RST_INITIAL;
			left_q  <= RST_LEFT;
			right_q <= RST_RIGHT;
			gain_q  <= RST_GAIN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INITIAL: init_q  <= cfg_data;
				CFG_LEFT:    left_q  <= cfg_data;
				CFG_RIGHT:   right_q <= cfg_data;
				CFG_GAIN:    gain_q  <= cfg_data[GAIN_W-1:0];
				default:     ;
			endcase
		end
	end

	// issue slots 0..NUM_POINTS; slot s < NUM_POINTS reads entry s, point s-1 leaves it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			restart_q <= 1'b0;
			virgin_q  <= 1'b1;
			cnt_q     <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				restart_q <= restart;
				cnt_q     <= '0;
			end else if (adv && issuing_q) begin
				if (cnt_q == S_END) begin
					issuing_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + SW'(1);
				end
			end
			// last write-back: every entry now holds a real value
			if (done) begin
				busy_q   <= 1'b0;
				virgin_q <= 1'b0;
			end
		end
	end

	hds_profile_mem #(
		.DEPTH(NUM_POINTS)
	) u_mem (
		.clk    (clk),
		.rd_en  (adv),
		.rd_addr(cnt_q[AW-1:0]),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	hds_stencil #(
		.NUM_POINTS(NUM_POINTS)
	) u_stencil (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.issue      (issue),
		.slot       (cnt_q),
		.rd_data    (rd_data),
		.virgin     (virgin_q),
		.init_val   (init_q),
		.left_val   (left_q),
		.right_val  (right_q),
		.gain       (gain_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.done       (done),
		.out_valid  (out_valid),
		.point_index(point_index),
		.temperature(temperature),
		.last       (last)
	);

	// slots are issued only inside a running item
	assert property (@(posedge clk) disable iff (!arst_n) issuing_q |-> busy_q)
		else $error("slot issued while idle");

	// once idle, only the final point may still wait on the output
	assert property (@(posedge clk) disable iff (!arst_n) (out_valid && !busy_q) |-> last)
		else $error("point pending after item completed");

	// an input transfer starts the sweep from entry zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (issuing_q && cnt_q == '0))
		else $error("sweep did not start at entry zero");

	// write-back of the last point ends the item
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy_q)
		else $error("item still busy after last write-back");

endmodule

[hw/rtl/hds_profile_mem.sv]
// ----------------------------------------------------------------------------
// hds_profile_mem: temperature profile storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hds_profile_mem import hds_pkg::*; #(
	parameter int DEPTH = NUM_POINTS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output temp_t         rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  temp_t         wr_data
);

	temp_t mem [DEPTH];
	temp_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/hds_stencil.sv]
// ----------------------------------------------------------------------------
// hds_stencil: three-point update pipeline and output register
// Slides a window over the old profile, computes the diffusion update,
// writes it back and presents one point per transfer.
// ----------------------------------------------------------------------------
module hds_stencil import hds_pkg::*; #(
	parameter int NUM_POINTS = NUM_POINTS_DEF,
	localparam int AW = $clog2(NUM_POINTS),
	localparam int SW = $clog2(NUM_POINTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  issue_t           issue,
	input  logic [SW-1:0]    slot,
	input  temp_t            rd_data,
	input  logic             virgin,
	input  temp_t            init_val,
	input  temp_t            left_val,
	input  temp_t            right_val,
	input  gain_t            gain,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output temp_t            wr_data,
	output logic             done,
	output logic             out_valid,
	output logic [IDX_W-1:0] point_index,
	output temp_t            temperature,
	output logic             last
);

	localparam logic [AW-1:0] P_LAST = AW'(NUM_POINTS - 1);
	localparam logic [SW-1:0] S_LAST = SW'(NUM_POINTS - 1);

	// stage 1: slot with its read data
	logic          valid_s1;
	logic          restart_s1;
	logic [SW-1:0] slot_s1;
	temp_t         n0_q;
	temp_t         n1_q;

	// stage 2: laplacian
	logic                    valid_s2;
	logic                    hold_s2;
	logic [AW-1:0]           p_s2;
	temp_t                   c_s2;
	logic signed [LAP_W-1:0] lap_s2;

	// stage 3: product
	logic                     valid_s3;
	logic                     hold_s3;
	logic [AW-1:0]            p_s3;
	temp_t                    c_s3;
	logic signed [PROD_W-1:0] prod_s3;

	// output register
	logic             out_valid_q;
	logic [IDX_W-1:0] point_index_q;
	temp_t            temperature_q;
	logic             last_q;

	temp_t                    old_val;
	temp_t                    rst_val;
	temp_t                    load_val;
	logic [AW-1:0]            p_cur;
	logic signed [LAP_W-1:0]  lap;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0]  sum;
	temp_t                    res;

	// an entry never written yet holds the power-on profile
	always_comb begin
		if (slot_s1 == '0) begin
			rst_val = RST_LEFT;
		end else if (slot_s1 == S_LAST) begin
			rst_val = RST_RIGHT;
		end else begin
			rst_val = RST_INITIAL;
		end
		old_val = virgin ? rst_val : rd_data;

		p_cur = AW'(slot_s1 - SW'(1));
		if (p_cur == '0) begin
			load_val = left_val;
		end else if (p_cur == P_LAST) begin
			load_val = right_val;
		end else begin
			load_val = init_val;
		end

		lap = LAP_W'(old_val) + LAP_W'(n0_q) - (LAP_W'(n1_q) <<< 1);
	end

	assign prod = PROD_W'(lap_s2) * PROD_W'($signed({1'b0, gain}));

	always_comb begin
		sum = SUM_W'(c_s3) + SUM_W'($signed(prod_s3[PROD_W-1:GAIN_W]));
		res = hold_s3 ? c_s3 : sat_temp(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue.valid;
			valid_s2    <= valid_s1 && (slot_s1 != '0);
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			restart_s1 <= issue.restart;
			slot_s1    <= slot;
			if (valid_s1) begin
				n0_q <= n1_q;
				n1_q <= old_val;
			end

			hold_s2 <= restart_s1 || (p_cur == '0) || (p_cur == P_LAST);
			p_s2    <= p_cur;
			c_s2    <= restart_s1 ? load_val : n1_q;
			lap_s2  <= lap;

			hold_s3 <= hold_s2;
			p_s3    <= p_s2;
			c_s3    <= c_s2;
			prod_s3 <= prod;

			point_index_q <= IDX_W'(p_s3);
			temperature_q <= res;
			last_q        <= (p_s3 == P_LAST);
		end
	end

	assign wr_en   = adv && valid_s3;
	assign wr_addr = p_s3;
	assign wr_data = res;
	assign done    = wr_en && (p_s3 == P_LAST);

	assign out_valid   = out_valid_q;
	assign point_index = point_index_q;
	assign temperature = temperature_q;
	assign last        = last_q;

endmodule
